// ===== src/mft_pkg.sv =====
`default_nettype none
package mft_pkg;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_SET_CTX = 2'd2;
    localparam logic [1:0] CMD_RX      = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_PRESENT   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [2:0] ACT_BCAST     = 3'd0;
    localparam logic [2:0] ACT_MCAST     = 3'd1;
    localparam logic [2:0] ACT_NO_MATCH  = 3'd2;
    localparam logic [2:0] ACT_NO_FILTER = 3'd3;
    localparam logic [2:0] ACT_FILTER    = 3'd4;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam int          MCAST_BIT = 40;

    typedef struct packed {
        logic load;
        logic free_start;
        logic free_step;
        logic scan_start;
        logic scan_step;
        logic apply;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_add;
        logic rx_fast;
        logic free_hit;
        logic free_miss;
        logic scan_done;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== src/mft_ctrl.sv =====
`default_nettype none
module mft_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  mft_pkg::t_dp_stat     i_stat,
    output mft_pkg::t_ctl_cmd     o_cmd
);
    import mft_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_FREE     = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_APPLY    = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_stat.rx_fast) begin
                    n_state = S_APPLY;
                end else if (i_stat.is_add) begin
                    o_cmd.free_start = 1'b1;
                    n_state          = S_FREE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_FREE: begin
                o_cmd.free_step = 1'b1;
                priority if (i_stat.free_hit) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_stat.free_miss) begin
                    n_state = S_APPLY;
                end else begin
                    n_state = S_FREE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== src/mft_datapath.sv =====
`default_nettype none
module mft_datapath #(
    parameter int ENTRIES      = 256,
    parameter int CONTEXT_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  mft_pkg::t_ctl_cmd      i_cmd,
    output mft_pkg::t_dp_stat      o_stat,
    input  wire logic [1:0]        i_command,
    input  wire logic [47:0]       i_mac,
    input  wire logic [15:0]       i_context_req,
    input  wire logic [15:0]       i_ethertype,
    input  wire logic [7:0]        i_ip_protocol,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [7:0]             o_slot,
    output logic [2:0]             o_rx_action,
    output logic [15:0]            o_context_out
);
    import mft_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    logic [47:0]             mem_mac [ENTRIES];
    logic [CONTEXT_BITS-1:0] mem_ctx [ENTRIES];
    logic [ENTRIES-1:0]      r_valid;

    logic [1:0]              r_command;
    logic [47:0]             r_mac;
    logic [CONTEXT_BITS-1:0] r_ctx;
    logic [15:0]             r_ethertype;
    logic [7:0]              r_proto;

    logic [IW-1:0]           r_fp;
    logic [IW-1:0]           r_f;
    logic [CW-1:0]           r_n;
    logic                    r_free_ok;
    logic [IW-1:0]           r_free_slot;

    logic [CW-1:0]           r_a;
    logic                    r_pend;
    logic [IW-1:0]           r_pidx;
    logic [47:0]             r_rd_mac;
    logic [CONTEXT_BITS-1:0] r_rd_ctx;
    logic                    r_found;
    logic [IW-1:0]           r_hit_idx;
    logic [CONTEXT_BITS-1:0] r_hit_ctx;

    logic                    w_rx_fast;
    logic                    w_free_hit;
    logic                    w_cmp_hit;
    logic                    w_issue;
    logic                    w_wr_mac;
    logic                    w_wr_ctx;
    logic [IW-1:0]           w_wr_idx;
    logic                    w_filter;

    assign w_rx_fast  = (r_command == CMD_RX) && ((r_mac == MAC_BCAST) || r_mac[MCAST_BIT]);
    assign w_free_hit = (r_n != LAST_CNT) && !r_valid[r_f];
    assign w_cmp_hit  = r_pend && r_valid[r_pidx] && (r_rd_mac == r_mac);
    assign w_issue    = (r_a != LAST_CNT);
    assign w_filter   = (r_hit_ctx != '0) && (r_ethertype == ETYPE_IPV4) &&
                        ((r_proto == PROTO_TCP) || (r_proto == PROTO_UDP));

    always_comb begin
        o_stat.is_add    = (r_command == CMD_ADD);
        o_stat.rx_fast   = w_rx_fast;
        o_stat.free_hit  = w_free_hit;
        o_stat.free_miss = (r_n == LAST_CNT);
        o_stat.scan_done = w_cmp_hit || (!w_issue && !r_pend);
    end

    assign w_wr_mac = i_cmd.apply && (r_command == CMD_ADD) && r_free_ok && !r_found;
    assign w_wr_ctx = w_wr_mac || (i_cmd.apply && (r_command == CMD_SET_CTX) && r_found);
    assign w_wr_idx = (r_command == CMD_ADD) ? r_free_slot : r_hit_idx;

    always_ff @(posedge i_clk) begin
        if (w_wr_mac) begin
            mem_mac[w_wr_idx] <= r_mac;
        end
        if (w_wr_ctx) begin
            mem_ctx[w_wr_idx] <= r_ctx;
        end
        r_rd_mac <= mem_mac[r_a[IW-1:0]];
        r_rd_ctx <= mem_ctx[r_a[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fp    <= '0;
        end else begin
            if (i_cmd.free_step && w_free_hit) begin
                r_fp <= r_f;
            end
            if (w_wr_mac) begin
                r_valid[w_wr_idx] <= 1'b1;
            end else if (i_cmd.apply && (r_command == CMD_REMOVE) && r_found) begin
                r_valid[w_wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command   <= i_command;
            r_mac       <= i_mac;
            r_ctx       <= CONTEXT_BITS'(i_context_req);
            r_ethertype <= i_ethertype;
            r_proto     <= i_ip_protocol;
            r_free_ok   <= 1'b0;
            r_found     <= 1'b0;
        end
        if (i_cmd.free_start) begin
            r_f <= r_fp;
            r_n <= '0;
        end else if (i_cmd.free_step) begin
            if (w_free_hit) begin
                r_free_ok   <= 1'b1;
                r_free_slot <= r_f;
            end else begin
                r_f <= (r_f == LAST_IDX) ? '0 : r_f + 1'b1;
                r_n <= r_n + 1'b1;
            end
        end
        if (i_cmd.scan_start) begin
            r_a    <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_pend <= w_issue && !w_cmp_hit;
            r_pidx <= r_a[IW-1:0];
            if (w_issue) begin
                r_a <= r_a + 1'b1;
            end
            if (w_cmp_hit) begin
                r_found   <= 1'b1;
                r_hit_idx <= r_pidx;
                r_hit_ctx <= r_rd_ctx;
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.apply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            o_status      <= ST_OK;
            o_slot        <= '0;
            o_rx_action   <= ACT_BCAST;
            o_context_out <= '0;
            unique case (r_command)
                CMD_ADD: begin
                    priority if (!r_free_ok) begin
                        o_status <= ST_NO_SPACE;
                    end else if (r_found) begin
                        o_status <= ST_PRESENT;
                        o_slot   <= 8'(r_hit_idx);
                    end else begin
                        o_slot <= 8'(r_free_slot);
                    end
                end
                CMD_REMOVE, CMD_SET_CTX: begin
                    if (r_found) begin
                        o_slot <= 8'(r_hit_idx);
                    end else begin
                        o_status <= ST_NOT_FOUND;
                    end
                end
                CMD_RX: begin
                    priority if (r_mac == MAC_BCAST) begin
                        o_rx_action <= ACT_BCAST;
                    end else if (r_mac[MCAST_BIT]) begin
                        o_rx_action <= ACT_MCAST;
                    end else if (!r_found) begin
                        o_status    <= ST_NOT_FOUND;
                        o_rx_action <= ACT_NO_MATCH;
                    end else begin
                        o_slot <= 8'(r_hit_idx);
                        if (w_filter) begin
                            o_rx_action   <= ACT_FILTER;
                            o_context_out <= 16'(r_hit_ctx);
                        end else begin
                            o_rx_action <= ACT_NO_FILTER;
                        end
                    end
                end
                default: begin
                    o_status <= ST_OK;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/mac_forward_table.sv =====
// broadcast/multicast lookups are fast: they skip both walks below
// add walks the valid bits from the free pointer one slot a cycle; if it finds a
// free slot it, like all commands but fast lookups, walks the mac memory one
// entry a cycle until a match or the end; one command at a time; busy stays high
// until the result beat, in whose cycle a new command can be taken; the receiver
// cannot stall; synchronous reset clears all valid bits at once
`default_nettype none
module mac_forward_table #(
    parameter int ENTRIES      = 256,
    parameter int CONTEXT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [47:0] i_mac,
    input  wire logic [15:0] i_context_req,
    input  wire logic [15:0] i_ethertype,
    input  wire logic [7:0]  i_ip_protocol,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [7:0]       o_slot,
    output logic [2:0]       o_rx_action,
    output logic [15:0]      o_context_out
);
    import mft_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    mft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    mft_datapath #(
        .ENTRIES      (ENTRIES),
        .CONTEXT_BITS (CONTEXT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_command     (i_command),
        .i_mac         (i_mac),
        .i_context_req (i_context_req),
        .i_ethertype   (i_ethertype),
        .i_ip_protocol (i_ip_protocol),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_rx_action   (o_rx_action),
        .o_context_out (o_context_out)
    );

endmodule
`default_nettype wire
